/* rtl/core/fdmd_pkg.sv */
// Package: constants, register codes and types of the frame difference motion detector.
package fdmd_pkg;

    // Store geometry
    localparam int MAX_PIXELS = 16384;
    localparam int IDX_W      = $clog2(MAX_PIXELS);

    // Field widths
    localparam int PIXEL_W  = 8;
    localparam int SIZE_W   = 15;
    localparam int COUNT_W  = 15;
    localparam int SUM_W    = 22;
    localparam int SENS_W   = 7;
    localparam int PCT_W    = 7;
    localparam int SKIP_W   = 8;
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 15;
    localparam int THR_W    = 22;

    // Saturation limits of the accumulators
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

    // Background blend weight of the new pixel (Q16), the old one keeps the rest
    localparam int W_NEW = 1311;

    // Per-hit step of the scaled motion count
    localparam logic [THR_W-1:0] PERCENT_STEP = THR_W'(100);

    // Configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_SENSITIVITY = 3'd1,
        CFG_NOISE       = 3'd2,
        CFG_MIN_PIXELS  = 3'd3,
        CFG_PERCENT     = 3'd4,
        CFG_FRAME_SKIP  = 3'd5,
        CFG_FRAME_SIZE  = 3'd6
    } cfg_index_t;

    // Kind of the frame in progress
    typedef enum logic [1:0] {
        KIND_SKIP   = 2'd0,
        KIND_CALIB  = 2'd1,
        KIND_DETECT = 2'd2
    } frame_kind_t;

endpackage

/* rtl/core/fdmd_if.sv */
// Interfaces: pixel input channel and frame result channel.
interface fdmd_pixel_if import fdmd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface fdmd_result_if import fdmd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] motion_count;
    logic [SUM_W-1:0]   brightness_sum;
    logic               motion_flag;

    modport source (output valid, output motion_count, output brightness_sum,
                    output motion_flag, input ready);
    modport sink   (input valid, input motion_count, input brightness_sum,
                    input motion_flag, output ready);
endinterface

/* rtl/core/fdmd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fdmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/frame_difference_motion_detector_top.sv */
// Top level: frame difference motion detector with background and previous-frame stores.
// Throughput: one pixel per cycle; a frame's last pixel waits only while the last result waits.
// Result: the last pixel is registered in stage 1, then its result in the output register.
// Pipeline: address and frame control at input, RAM read, compute and write-back in stage 1.
// Reset: control and configuration registers take their defaults; the stores are not cleared,
// the first processed frame after reset fills them and gives no result.
module frame_difference_motion_detector_top import fdmd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    fdmd_pixel_if.sink           pix_in,
    fdmd_result_if.source        res_out,
    input  logic                 cfg_we,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [CFG_D_W-1:0]   cfg_wdata
);

    // Configuration registers
    logic                mode_reg;
    logic [SENS_W-1:0]   sensitivity_reg;
    logic [PIXEL_W-1:0]  noise_reg;
    logic [COUNT_W-1:0]  min_pixels_reg;
    logic [PCT_W-1:0]    percent_reg;
    logic [SKIP_W-1:0]   frame_skip_reg;
    logic [SIZE_W-1:0]   frame_size_reg;

    // Frame control state
    logic [IDX_W-1:0]    pixel_index_reg, pixel_index_next;
    logic [SKIP_W-1:0]   skip_phase_reg, skip_phase_next;
    frame_kind_t         frame_kind_reg, frame_kind_next;
    logic                calibrated_reg, calibrated_next;

    // Stage 1
    logic                s1_valid_reg, s1_valid_next;
    frame_kind_t         s1_kind_reg;
    logic                s1_last_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [PIXEL_W-1:0]  s1_px_reg;
    logic [THR_W-1:0]    s1_thr_reg;
    logic                fwd_hit_reg, fwd_hit_next;
    logic [PIXEL_W-1:0]  fwd_bg_reg;
    logic [PIXEL_W-1:0]  fwd_prev_reg;

    // Accumulators
    logic [COUNT_W-1:0]  motion_acc_reg, motion_acc_next;
    logic [THR_W-1:0]    scaled_acc_reg, scaled_acc_next;
    logic [SUM_W-1:0]    bright_acc_reg, bright_acc_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [SUM_W-1:0]    out_sum_reg;
    logic                out_det_reg;

    // Combinational
    logic                accept;
    logic [SIZE_W-1:0]   size_eff;
    logic                idx_last;
    frame_kind_t         kind_now;
    logic [THR_W-1:0]    thr_now;
    logic [PIXEL_W-1:0]  bg_q, prev_q;
    logic [PIXEL_W-1:0]  bg_cur, prev_cur;
    logic [PIXEL_W-1:0]  diff_bg, diff_prev, diff_adv, diff_sel;
    logic                motion_hit;
    logic signed [PIXEL_W:0]   blend_delta;
    logic signed [20:0]        blend_prod;
    logic [23:0]         blend_sum;
    logic [PIXEL_W-1:0]  bg_new;
    logic                s1_emit;
    logic                s1_adv;
    logic                wr_en;
    logic [PIXEL_W-1:0]  wr_bg, wr_prev;
    logic [COUNT_W-1:0]  count_upd;
    logic [THR_W-1:0]    scaled_upd;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_upd;
    logic                det_upd;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b1;
            sensitivity_reg <= SENS_W'(50);
            noise_reg       <= PIXEL_W'(15);
            min_pixels_reg  <= COUNT_W'(100);
            percent_reg     <= PCT_W'(5);
            frame_skip_reg  <= '0;
            frame_size_reg  <= SIZE_W'(16384);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_MODE:        mode_reg        <= cfg_wdata[0];
                CFG_SENSITIVITY: sensitivity_reg <= cfg_wdata[SENS_W-1:0];
                CFG_NOISE:       noise_reg       <= cfg_wdata[PIXEL_W-1:0];
                CFG_MIN_PIXELS:  min_pixels_reg  <= cfg_wdata[COUNT_W-1:0];
                CFG_PERCENT:     percent_reg     <= cfg_wdata[PCT_W-1:0];
                CFG_FRAME_SKIP:  frame_skip_reg  <= cfg_wdata[SKIP_W-1:0];
                CFG_FRAME_SIZE:  frame_size_reg  <= cfg_wdata[SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input side: frame size, frame kind and end of frame
    always_comb
    begin
        accept = pix_in.valid && pix_in.ready;

        if (frame_size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (frame_size_reg > SIZE_W'(MAX_PIXELS))
            size_eff = SIZE_W'(MAX_PIXELS);
        else
            size_eff = frame_size_reg;

        idx_last = (32'(pixel_index_reg) + 32'd1) >= 32'(size_eff);
        thr_now  = THR_W'(percent_reg) * THR_W'(size_eff);

        skip_phase_next = skip_phase_reg;
        kind_now        = frame_kind_reg;
        if (pixel_index_reg == '0)
        begin
            if (skip_phase_reg >= frame_skip_reg)
            begin
                skip_phase_next = '0;
                kind_now        = calibrated_reg ? KIND_DETECT : KIND_CALIB;
            end
            else
            begin
                skip_phase_next = skip_phase_reg + SKIP_W'(1);
                kind_now        = KIND_SKIP;
            end
        end

        frame_kind_next  = kind_now;
        pixel_index_next = idx_last ? '0 : pixel_index_reg + IDX_W'(1);
        calibrated_next  = calibrated_reg || (idx_last && kind_now == KIND_CALIB);
    end

    // Frame control registers, advance on each transfer in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_index_reg <= '0;
            skip_phase_reg  <= '0;
            frame_kind_reg  <= KIND_SKIP;
            calibrated_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pixel_index_reg <= pixel_index_next;
            skip_phase_reg  <= skip_phase_next;
            frame_kind_reg  <= frame_kind_next;
            calibrated_reg  <= calibrated_next;
        end
    end

    // Stores, read at the input index, written back from stage 1
    fdmd_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_PIXELS)) u_bg_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg),
        .wr_data (wr_bg),
        .rd_en   (accept),
        .rd_addr (pixel_index_reg),
        .rd_data (bg_q)
    );

    fdmd_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_PIXELS)) u_prev_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx_reg),
        .wr_data (wr_prev),
        .rd_en   (accept),
        .rd_addr (pixel_index_reg),
        .rd_data (prev_q)
    );

    // Stage 1: difference, motion test, background blend, accumulate
    always_comb
    begin
        // Take the write-back of the previous pixel when it hit the same entry
        bg_cur   = fwd_hit_reg ? fwd_bg_reg   : bg_q;
        prev_cur = fwd_hit_reg ? fwd_prev_reg : prev_q;

        diff_bg   = (s1_px_reg > bg_cur)   ? s1_px_reg - bg_cur   : bg_cur - s1_px_reg;
        diff_prev = (s1_px_reg > prev_cur) ? s1_px_reg - prev_cur : prev_cur - s1_px_reg;

        // Drop noise, then double with saturation
        if (diff_bg < noise_reg)
            diff_adv = '0;
        else if (diff_bg[PIXEL_W-1])
            diff_adv = '1;
        else
            diff_adv = {diff_bg[PIXEL_W-2:0], 1'b0};

        diff_sel   = mode_reg ? diff_adv : diff_prev;
        motion_hit = diff_sel > {1'b0, sensitivity_reg};

        // bg*(65536-W) + px*W = bg*65536 + (px-bg)*W
        blend_delta = $signed({1'b0, s1_px_reg}) - $signed({1'b0, bg_cur});
        blend_prod  = blend_delta * $signed(21'(W_NEW));
        blend_sum   = {bg_cur, 16'h0000} + {{3{blend_prod[20]}}, blend_prod};
        bg_new      = blend_sum[23:16];

        if (s1_kind_reg == KIND_CALIB)
            wr_bg = s1_px_reg;
        else
            wr_bg = bg_new;
        wr_prev = s1_px_reg;

        s1_emit = s1_valid_reg && s1_last_reg && (s1_kind_reg == KIND_DETECT);
        s1_adv  = s1_valid_reg && !(s1_emit && out_valid_reg && !res_out.ready);
        wr_en   = s1_adv && (s1_kind_reg != KIND_SKIP);

        // Saturating accumulator updates
        if (motion_hit && (motion_acc_reg != COUNT_MAX))
        begin
            count_upd  = motion_acc_reg + COUNT_W'(1);
            scaled_upd = scaled_acc_reg + PERCENT_STEP;
        end
        else
        begin
            count_upd  = motion_acc_reg;
            scaled_upd = scaled_acc_reg;
        end
        sum_wide = {1'b0, bright_acc_reg} + (SUM_W+1)'(s1_px_reg);
        sum_upd  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        det_upd  = (count_upd >= min_pixels_reg) && (scaled_upd >= s1_thr_reg);

        motion_acc_next = motion_acc_reg;
        scaled_acc_next = scaled_acc_reg;
        bright_acc_next = bright_acc_reg;
        if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                motion_acc_next = '0;
                scaled_acc_next = '0;
                bright_acc_next = '0;
            end
            else if (s1_kind_reg == KIND_DETECT)
            begin
                motion_acc_next = count_upd;
                scaled_acc_next = scaled_upd;
                bright_acc_next = sum_upd;
            end
        end

        // Stage 1 occupancy and forwarding
        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        fwd_hit_next  = wr_en && (s1_idx_reg == pixel_index_reg);

        // Output register: load on emit, drop on transfer out
        if (s1_emit && s1_adv)
            out_valid_next = 1'b1;
        else if (res_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign pix_in.ready = !s1_valid_reg || s1_adv;

    // Stage 1 control and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_kind_reg    <= KIND_SKIP;
            s1_last_reg    <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            motion_acc_reg <= '0;
            scaled_acc_reg <= '0;
            bright_acc_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            motion_acc_reg <= motion_acc_next;
            scaled_acc_reg <= scaled_acc_next;
            bright_acc_reg <= bright_acc_next;
            out_valid_reg  <= out_valid_next;
            if (accept)
            begin
                s1_kind_reg <= kind_now;
                s1_last_reg <= idx_last;
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    // Stage 1 payload, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= pixel_index_reg;
            s1_px_reg    <= pix_in.pixel;
            s1_thr_reg   <= thr_now;
            fwd_bg_reg   <= wr_bg;
            fwd_prev_reg <= wr_prev;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s1_emit && s1_adv)
        begin
            out_count_reg <= count_upd;
            out_sum_reg   <= sum_upd;
            out_det_reg   <= det_upd;
        end
    end

    assign res_out.valid          = out_valid_reg;
    assign res_out.motion_count   = out_count_reg;
    assign res_out.brightness_sum = out_sum_reg;
    assign res_out.motion_flag    = out_det_reg;

`ifndef SYNTHESIS
    // A result appears only from a frame end leaving stage 1
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_emit && s1_adv))
        else $error("result raised without a frame end in stage 1");

    // Calibration is never lost once done
    a_calib_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        calibrated_reg |=> calibrated_reg)
        else $error("calibrated flag cleared");

    // Detection frames run only on filled stores
    a_detect_after_calib: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_kind_reg == KIND_DETECT) |-> calibrated_reg)
        else $error("detection frame before calibration");

    // Stage 1 stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> (out_valid_reg && !res_out.ready && s1_emit))
        else $error("stage 1 stalled without a waiting result");
`endif

endmodule
